@@ hdl/sata_dma_transfer_sequencer_unit_defines.svh @@
// Assertion macros for the SATA DMA transfer sequencer.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SATA_DMA_TRANSFER_SEQUENCER_UNIT_DEFINES_SVH
`define SATA_DMA_TRANSFER_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define SDTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SDTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sdts_pkg.sv @@
// Shared types and constants for the SATA DMA transfer sequencer.
// No dependencies; imported by every module of the block.
package sdts_pkg;

  localparam int unsigned MaxChunkSectors = 8;  // sectors per command, 1..8

  localparam logic [7:0] CmdReadDmaExt  = 8'h25;
  localparam logic [7:0] CmdWriteDmaExt = 8'h35;

  localparam int unsigned TfdBusyBit = 7;
  localparam int unsigned TfdDrqBit  = 3;
  localparam int unsigned TfdErrBit  = 0;

  localparam logic [15:0] ReadyTimeoutRst = 16'd1000;
  localparam logic [15:0] DoneTimeoutRst  = 16'd5000;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READY = 2'd1,
    PH_DONE  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ISSUE  = 2'd1,
    ACT_FINISH = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_READY_TMO    = 3'd1,
    ST_TASK_FILE    = 3'd2,
    ST_DONE_TMO     = 3'd3,
    ST_DEVICE_ERROR = 3'd4
  } status_e;

  typedef enum logic {
    CFG_READY_TIMEOUT = 1'b0,
    CFG_DONE_TIMEOUT  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [47:0] lba;
    logic [31:0] sector_count;
    logic        write_dir;
    logic [7:0]  tfd_status;
    logic        slot_busy;
    logic        task_file_error;
  } item_t;

  typedef struct packed {
    action_e     action;
    logic [7:0]  command_code;
    logic [47:0] chunk_lba;
    logic [3:0]  chunk_sectors;
    logic [11:0] prd_byte_count;
    logic        is_write;
    status_e     status_code;
  } result_t;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] elapsed;
  } seq_status_t;

endpackage

@@ hdl/sdts_out_q.sv @@
// Two-entry result queue between the sequencer and the master stream.
// Depends on sdts_pkg for result_t.
module sdts_out_q import sdts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    pop_i,
  output result_t data_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign valid_o = (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/sdts_seq.sv @@
// Request, status and tick handling of the transfer sequencer: phase state,
// chunk bookkeeping and timeouts. Depends on sdts_pkg.
module sdts_seq import sdts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  op_i,
  input  item_t       item_i,
  input  logic [15:0] ready_timeout_i,
  input  logic [15:0] done_timeout_i,
  output logic        res_valid_o,
  output result_t     res_o,
  output seq_status_t stat_o
);

  phase_e      phase_q, phase_d;
  logic [47:0] block_q, block_d;
  logic [31:0] left_q, left_d;
  logic [3:0]  chunk_q, chunk_d;
  logic        dir_q, dir_d;
  logic [15:0] elapsed_q, elapsed_d;

  logic        emit;
  action_e     act;
  status_e     stat;
  logic [31:0] left_after;
  logic [31:0] chunk_src;
  logic [3:0]  next_chunk;
  logic [12:0] bytes;

  // Sectors still to go once a chunk gets loaded: the new request when idle,
  // otherwise what is left after the chunk that just completed.
  assign chunk_src = (phase_q == PH_IDLE) ? item_i.sector_count : left_after;

  // Next chunk size from the sectors still to go (after this step's update).
  always_comb begin
    if (chunk_src < 32'(MaxChunkSectors)) begin
      next_chunk = chunk_src[3:0];
    end else begin
      next_chunk = 4'(MaxChunkSectors);
    end
  end

  assign left_after = left_q - 32'(chunk_q);

  // Next state. Chunk load is folded in: chunk_d comes from left_d.
  always_comb begin
    phase_d   = phase_q;
    block_d   = block_q;
    left_d    = left_q;
    chunk_d   = chunk_q;
    dir_d     = dir_q;
    elapsed_d = elapsed_q;
    emit      = 1'b0;
    act       = ACT_FINISH;
    stat      = ST_OK;
    if (accept_i) begin
      unique case (op_i)
        OP_REQUEST: begin
          if (phase_q == PH_IDLE) begin
            block_d   = item_i.lba;
            left_d    = item_i.sector_count;
            dir_d     = item_i.write_dir;
            elapsed_d = 16'd0;
            emit      = 1'b1;
            if (item_i.sector_count == 32'd0) begin
              chunk_d = 4'd0;
              act     = ACT_FINISH;
            end else begin
              chunk_d = next_chunk;
              phase_d = PH_READY;
              act     = ACT_LOAD;
            end
          end
        end
        OP_SAMPLE: begin
          unique case (phase_q)
            PH_READY: begin
              if (!item_i.tfd_status[TfdBusyBit] && !item_i.tfd_status[TfdDrqBit]) begin
                phase_d   = PH_DONE;
                elapsed_d = 16'd0;
                emit      = 1'b1;
                act       = ACT_ISSUE;
              end
            end
            PH_DONE: begin
              if (item_i.slot_busy) begin
                if (item_i.task_file_error) begin
                  phase_d   = PH_IDLE;
                  elapsed_d = 16'd0;
                  emit      = 1'b1;
                  stat      = ST_TASK_FILE;
                end
              end else if (item_i.tfd_status[TfdErrBit]) begin
                phase_d   = PH_IDLE;
                elapsed_d = 16'd0;
                emit      = 1'b1;
                stat      = ST_DEVICE_ERROR;
              end else begin
                left_d    = left_after;
                elapsed_d = 16'd0;
                emit      = 1'b1;
                if (left_after == 32'd0) begin
                  phase_d = PH_IDLE;
                end else begin
                  block_d = block_q + 48'(chunk_q);
                  chunk_d = next_chunk;
                  phase_d = PH_READY;
                  act     = ACT_LOAD;
                end
              end
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          unique case (phase_q)
            PH_READY: begin
              if (elapsed_q >= ready_timeout_i) begin
                phase_d   = PH_IDLE;
                elapsed_d = 16'd0;
                emit      = 1'b1;
                stat      = ST_READY_TMO;
              end else begin
                elapsed_d = elapsed_q + 16'd1;
              end
            end
            PH_DONE: begin
              if (elapsed_q >= done_timeout_i) begin
                phase_d   = PH_IDLE;
                elapsed_d = 16'd0;
                emit      = 1'b1;
                stat      = ST_DONE_TMO;
              end else begin
                elapsed_d = elapsed_q + 16'd1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Result fields follow the updated state.
  assign bytes = {chunk_d, 9'd0};

  always_comb begin
    res_valid_o          = emit;
    res_o.action         = act;
    res_o.command_code   = dir_d ? CmdWriteDmaExt : CmdReadDmaExt;
    res_o.chunk_lba      = block_d;
    res_o.chunk_sectors  = chunk_d;
    res_o.prd_byte_count = (chunk_d == 4'd0) ? 12'd0 : 12'(bytes - 13'd1);
    res_o.is_write       = dir_d;
    res_o.status_code    = stat;
  end

  assign stat_o.phase   = phase_q;
  assign stat_o.elapsed = elapsed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      block_q   <= 48'd0;
      left_q    <= 32'd0;
      chunk_q   <= 4'd0;
      dir_q     <= 1'b0;
      elapsed_q <= 16'd0;
    end else begin
      phase_q   <= phase_d;
      block_q   <= block_d;
      left_q    <= left_d;
      chunk_q   <= chunk_d;
      dir_q     <= dir_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

@@ hdl/sata_dma_transfer_sequencer_unit.sv @@
// SATA DMA transfer sequencer, top level: stream ports, config registers,
// assertions. Depends on sdts_pkg, sdts_seq, sdts_out_q and the defines header.
//
// Usage:
//  - Slave stream carries events: tuser is the op (request, status sample,
//    timer tick); tdata carries the request and status fields.
//  - A request is split into chunks of up to 8 sectors. Per chunk the master
//    stream gives a load-descriptor beat, then an issue beat once a sample
//    shows BSY and DRQ clear, then the next chunk once the slot completes.
//    A finished beat (tuser = 2) closes the request with its status code.
//  - A beat's result, if any, goes combinationally from the sequencer into the
//    result queue when the beat is accepted and reaches the master side from
//    there. Beats are taken one per cycle while the result queue has room.
//  - The result queue holds two beats; s_axis_tready drops only when it is
//    full, so events that give no result keep flowing until then. A stalled
//    master side holds its beat stable.
//  - Config: cfg_index_i 0 = ready timeout, 1 = done timeout (ticks). Always
//    ready; write only while idle.
//  - Reset: sequencer idle, queue empty, timeouts 1000 and 5000 ticks.
`include "sata_dma_transfer_sequencer_unit_defines.svh"

module sata_dma_transfer_sequencer_unit import sdts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // lba[47:0], sector_count[79:48], write_dir[80], tfd_status[88:81],
  // slot_busy[89], task_file_error[90], zero[95:91]
  input  logic [95:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command_code[7:0], chunk_lba[55:8], chunk_sectors[59:56],
  // prd_byte_count[71:60], is_write[72], status_code[75:73], zero[79:76]
  output logic [79:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] ready_tmo_q;
  logic [15:0] done_tmo_q;
  logic        in_beat;
  item_t       item;
  logic        res_valid;
  result_t     res;
  result_t     out_res;
  seq_status_t seq_stat;
  logic        q_space;

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_tmo_q <= ReadyTimeoutRst;
      done_tmo_q  <= DoneTimeoutRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_READY_TIMEOUT: ready_tmo_q <= cfg_data_i;
        CFG_DONE_TIMEOUT:  done_tmo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input unpacking
  assign item.lba             = s_axis_tdata[47:0];
  assign item.sector_count    = s_axis_tdata[79:48];
  assign item.write_dir       = s_axis_tdata[80];
  assign item.tfd_status      = s_axis_tdata[88:81];
  assign item.slot_busy       = s_axis_tdata[89];
  assign item.task_file_error = s_axis_tdata[90];

  assign s_axis_tready = q_space;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  sdts_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_beat),
    .op_i            (s_axis_tuser),
    .item_i          (item),
    .ready_timeout_i (ready_tmo_q),
    .done_timeout_i  (done_tmo_q),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .stat_o          (seq_stat)
  );

  sdts_out_q u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .space_o (q_space),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .data_o  (out_res)
  );

  // Output packing
  assign m_axis_tuser = out_res.action;
  assign m_axis_tdata = {4'd0, out_res.status_code, out_res.is_write,
                         out_res.prd_byte_count, out_res.chunk_sectors,
                         out_res.chunk_lba, out_res.command_code};

  // Checks
  `SDTS_ASSERT_NEXT(a_issue_to_done, res_valid && res.action == ACT_ISSUE, seq_stat.phase == PH_DONE && seq_stat.elapsed == 16'd0, "issue did not enter done phase")
  `SDTS_ASSERT_NEXT(a_load_to_ready, res_valid && res.action == ACT_LOAD, seq_stat.phase == PH_READY && seq_stat.elapsed == 16'd0 && res.chunk_sectors != 4'd0, "load did not arm ready phase")
  `SDTS_ASSERT_NOW(a_status_on_finish, res_valid && res.status_code != ST_OK, res.action == ACT_FINISH, "error status outside a finished beat")
  `SDTS_ASSERT_NOW(a_result_has_room, res_valid, in_beat, "result produced without an accepted beat")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for sata_dma_transfer_sequencer_unit: streams request, status
// and tick beats, predicts every descriptor, issue and finish beat and checks them in order.
// Depends on sdts_pkg and the RTL top level; needs no files or arguments.
module testbench;
  import sdts_pkg::*;

  localparam int         ClkPeriod  = 10;
  localparam int         HoldCycles = 300;   // one long receiver hold-off
  localparam int         StallLimit = 2000;  // cycles with no beat accepted anywhere
  localparam int         PhaseItems = 300;
  localparam logic [1:0] OpUnused   = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    item_t      f;
  } evt_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic [95:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i   = 1'b0;
  logic [15:0] cfg_data_i    = '0;

  // Shadow of the sequencer and its timeout registers
  phase_e      seq_phase   = PH_IDLE;
  logic [47:0] seq_block   = '0;
  logic [31:0] seq_left    = '0;
  logic [3:0]  seq_chunk   = '0;
  logic        seq_write   = 1'b0;
  logic [15:0] seq_ticks   = '0;
  logic [15:0] ready_limit = ReadyTimeoutRst;
  logic [15:0] done_limit  = DoneTimeoutRst;

  result_t pending_actions[$];
  evt_t    event_backlog[$];
  int      queued_total   = 0;
  int      accepted_total = 0;
  int      mismatches     = 0;
  int      quiet_cycles   = 0;
  int      rx_hold_left   = HoldCycles;
  bit      calm           = 1'b0;
  bit      rx_hold_req    = 1'b0;

  sata_dma_transfer_sequencer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------- prediction

  task automatic post_action(input action_e act, input status_e st);
    result_t     r;
    logic [12:0] bytes;
    bytes            = {seq_chunk, 9'd0};
    r.action         = act;
    r.command_code   = seq_write ? CmdWriteDmaExt : CmdReadDmaExt;
    r.chunk_lba      = seq_block;
    r.chunk_sectors  = seq_chunk;
    r.prd_byte_count = (bytes == 13'd0) ? 12'd0 : 12'(bytes - 13'd1);
    r.is_write       = seq_write;
    r.status_code    = st;
    pending_actions.push_back(r);
  endtask

  task automatic open_chunk();
    seq_chunk = (seq_left < MaxChunkSectors) ? seq_left[3:0] : 4'(MaxChunkSectors);
    seq_phase = PH_READY;
    seq_ticks = '0;
    post_action(ACT_LOAD, ST_OK);
  endtask

  task automatic end_transfer(input status_e st);
    seq_phase = PH_IDLE;
    seq_ticks = '0;
    post_action(ACT_FINISH, st);
  endtask

  task automatic advance_sequencer(input logic [1:0] op, input item_t f);
    case (op)
      OP_REQUEST: begin
        // a request while a transfer runs is dropped
        if (seq_phase == PH_IDLE) begin
          seq_block = f.lba;
          seq_left  = f.sector_count;
          seq_write = f.write_dir;
          seq_ticks = '0;
          if (seq_left == 0) begin
            seq_chunk = '0;
            end_transfer(ST_OK);
          end else begin
            open_chunk();
          end
        end
      end
      OP_SAMPLE: begin
        if (seq_phase == PH_READY) begin
          if (!f.tfd_status[TfdBusyBit] && !f.tfd_status[TfdDrqBit]) begin
            seq_phase = PH_DONE;
            seq_ticks = '0;
            post_action(ACT_ISSUE, ST_OK);
          end
        end else if (seq_phase == PH_DONE) begin
          if (f.slot_busy) begin
            if (f.task_file_error) end_transfer(ST_TASK_FILE);
          end else if (f.tfd_status[TfdErrBit]) begin
            end_transfer(ST_DEVICE_ERROR);
          end else begin
            seq_left = seq_left - 32'(seq_chunk);
            if (seq_left == 0) begin
              end_transfer(ST_OK);
            end else begin
              seq_block = seq_block + 48'(seq_chunk);  // wraps at 2^48
              open_chunk();
            end
          end
        end
      end
      OP_TICK: begin
        if (seq_phase == PH_READY) begin
          if (seq_ticks >= ready_limit) end_transfer(ST_READY_TMO);
          else seq_ticks++;
        end else if (seq_phase == PH_DONE) begin
          if (seq_ticks >= done_limit) end_transfer(ST_DONE_TMO);
          else seq_ticks++;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [47:0] rand_lba();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  task automatic offer(input logic [1:0] op, input logic [47:0] lba, input logic [31:0] cnt,
                       input logic wr, input logic [7:0] tfd, input logic slot,
                       input logic tferr);
    evt_t e;
    e.op                = op;
    e.f.lba             = lba;
    e.f.sector_count    = cnt;
    e.f.write_dir       = wr;
    e.f.tfd_status      = tfd;
    e.f.slot_busy       = slot;
    e.f.task_file_error = tferr;
    event_backlog.push_back(e);
    queued_total++;
  endtask

  task automatic offer_sample(input logic [7:0] tfd, input logic slot, input logic tferr);
    offer(OP_SAMPLE, rand_lba(), $urandom(), 1'($urandom_range(1)), tfd, slot, tferr);
  endtask

  task automatic offer_ticks(input int n);
    repeat (n) begin
      offer(OP_TICK, rand_lba(), $urandom(), 1'($urandom_range(1)), 8'($urandom()),
            1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // One chunk: wait for BSY/DRQ to clear, issue, wait for the slot. Some chunks fail.
  task automatic queue_chunk_steps(output bit failed);
    logic [7:0] tfd;
    int         roll;
    failed = 1'b0;
    repeat ($urandom_range(2)) begin
      tfd = 8'($urandom());
      if ($urandom_range(1)) tfd[TfdBusyBit] = 1'b1;
      else tfd[TfdDrqBit] = 1'b1;
      offer_sample(tfd, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    if (ready_limit <= 6 && $urandom_range(99) < 10) begin
      offer_ticks(ready_limit + 1);
      failed = 1'b1;
      return;
    end
    offer_ticks($urandom_range(ready_limit < 3 ? ready_limit : 3));
    tfd = 8'($urandom());
    tfd[TfdBusyBit] = 1'b0;
    tfd[TfdDrqBit]  = 1'b0;
    offer_sample(tfd, 1'($urandom_range(1)), 1'($urandom_range(1)));
    offer_ticks($urandom_range(done_limit < 3 ? done_limit : 3));
    repeat ($urandom_range(3)) offer_sample(8'($urandom()), 1'b1, 1'b0);
    roll = $urandom_range(99);
    if (roll < 6) begin
      offer_sample(8'($urandom()), 1'b1, 1'b1);
      failed = 1'b1;
    end else if (roll < 12 && done_limit <= 6) begin
      offer_ticks(done_limit + 1);
      failed = 1'b1;
    end else begin
      tfd = 8'($urandom());
      tfd[TfdErrBit] = (roll < 20);
      offer_sample(tfd, 1'b0, 1'($urandom_range(1)));
      failed = tfd[TfdErrBit];
    end
  endtask

  task automatic queue_transfer();
    logic [47:0] lba;
    logic [31:0] cnt;
    longint      chunks;
    longint      k;
    int          pick;
    bit          failed;
    pick = $urandom_range(99);
    if (pick < 8) cnt = '0;
    else if (pick < 16) cnt = 32'(8 * $urandom_range(1, 4));
    else if (pick < 90) cnt = 32'($urandom_range(1, 40));
    else cnt = $urandom();
    case ($urandom_range(3))
      0: lba = 48'($urandom_range(64));
      1: lba = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(40));
      default: lba = rand_lba();
    endcase
    offer(OP_REQUEST, lba, cnt, 1'($urandom_range(1)), 8'($urandom()),
          1'($urandom_range(1)), 1'($urandom_range(1)));
    chunks = (longint'(cnt) + 7) / 8;
    failed = 1'b0;
    for (k = 0; k < chunks && k < 4 && !failed; k++) queue_chunk_steps(failed);
    // long request: cut it short with a device error after a few chunks
    if (!failed && chunks > 4) begin
      offer_sample(8'h00, 1'b0, 1'b0);
      offer_sample(8'(1 << TfdErrBit), 1'b0, 1'b0);
    end
  endtask

  // Wait until every beat is taken and answered, close any open transfer, let the pipe drain.
  task automatic settle_sequencer();
    forever begin
      while (accepted_total != queued_total || pending_actions.size() != 0) @(posedge clk_i);
      if (seq_phase == PH_IDLE) break;
      if (seq_phase == PH_READY) offer_sample(8'h00, 1'b0, 1'b0);
      else offer_sample(8'(1 << TfdErrBit), 1'b0, 1'b0);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(input cfg_reg_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_READY_TIMEOUT) ready_limit = val;
    else done_limit = val;
  endtask

  initial begin : stimulus
    int          ph;
    int          target;
    logic [15:0] rt;
    logic [15:0] dt;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset timeouts: idle events, odd op, zero-length, wrap, ok and error outcomes
    offer_sample(8'h00, 1'b0, 1'b0);
    offer_ticks(1);
    offer(OpUnused, '1, '1, 1'b1, '1, 1'b1, 1'b1);
    offer(OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b1, 8'h00, 1'b0, 1'b0);
    offer(OP_REQUEST, 48'hFFFF_FFFF_FFFC, 32'd12, 1'b1, 8'h00, 1'b0, 1'b0);
    offer(OP_REQUEST, rand_lba(), 32'd5, 1'b0, 8'h00, 1'b0, 1'b0);  // dropped, busy
    offer_sample(8'h80, 1'b0, 1'b0);
    offer_sample(8'h08, 1'b0, 1'b0);
    offer_ticks(1);
    offer_sample(8'h01, 1'b1, 1'b1);
    offer_sample(8'h00, 1'b1, 1'b0);
    offer_ticks(1);
    offer_sample(8'hFE, 1'b0, 1'b0);  // chunk done, next block wraps past 2^48
    offer_sample(8'h00, 1'b0, 1'b0);
    offer_sample(8'h00, 1'b0, 1'b0);
    offer(OP_REQUEST, 48'd0, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, 1'b0);
    offer_sample(8'h00, 1'b0, 1'b0);
    offer_sample(8'h00, 1'b1, 1'b1);  // task file error
    offer(OP_REQUEST, 48'd1, 32'd1, 1'b0, 8'h00, 1'b0, 1'b0);
    offer_sample(8'h00, 1'b0, 1'b0);
    offer_sample(8'h01, 1'b0, 1'b0);  // device error bit
    settle_sequencer();

    // Zero timeouts: the first tick fails either wait
    write_timeout(CFG_READY_TIMEOUT, 16'd0);
    write_timeout(CFG_DONE_TIMEOUT, 16'd0);
    offer(OP_REQUEST, rand_lba(), 32'd8, 1'b0, 8'h00, 1'b0, 1'b0);
    offer_ticks(1);
    offer(OP_REQUEST, rand_lba(), 32'd3, 1'b1, 8'h00, 1'b0, 1'b0);
    offer_sample(8'h00, 1'b0, 1'b0);
    offer_ticks(1);
    settle_sequencer();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin rt = 16'd2;     dt = 16'd4;     end
        1: begin rt = 16'hFFFF;  dt = 16'hFFFF;  end
        2: begin rt = 16'd1;     dt = 16'd0;     end
        3: begin rt = 16'd5;     dt = 16'd3;     end
        4: begin rt = 16'($urandom_range(6)); dt = 16'($urandom_range(6)); end
        default: begin rt = 16'($urandom()); dt = 16'($urandom()); end
      endcase
      write_timeout(CFG_READY_TIMEOUT, rt);
      write_timeout(CFG_DONE_TIMEOUT, dt);
      calm = (ph == 2);
      target = queued_total + PhaseItems;
      while (queued_total < target) begin
        if ($urandom_range(99) < 10) begin
          offer(2'($urandom_range(3)), rand_lba(), $urandom(), 1'($urandom_range(1)),
                8'($urandom()), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          queue_transfer();
        end
      end
      // receiver stalls while a full phase of beats waits to go in
      if (ph == 1) rx_hold_req = 1'b1;
      settle_sequencer();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_actions.size() == 0) begin
      $display("PASS sata_dma_transfer_sequencer_unit");
    end else begin
      $display("FAIL sata_dma_transfer_sequencer_unit");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin : drive_events
    evt_t e;
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (event_backlog.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
        e = event_backlog.pop_front();
        s_axis_tuser  <= e.op;
        s_axis_tdata  <= {5'b0, e.f.task_file_error, e.f.slot_busy, e.f.tfd_status,
                          e.f.write_dir, e.f.sector_count, e.f.lba};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (rx_hold_req && rx_hold_left != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left  <= rx_hold_left - 1;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : watch_ports
    item_t   f;
    result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        f.lba             = s_axis_tdata[47:0];
        f.sector_count    = s_axis_tdata[79:48];
        f.write_dir       = s_axis_tdata[80];
        f.tfd_status      = s_axis_tdata[88:81];
        f.slot_busy       = s_axis_tdata[89];
        f.task_file_error = s_axis_tdata[90];
        advance_sequencer(s_axis_tuser, f);
        accepted_total++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_actions.size() == 0) begin
          $display("%0t ns: result beat expected none, got action %0d data 0x%0h",
                   $time, m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = pending_actions.pop_front();
          check_field("action", 48'(want.action), 48'(m_axis_tuser));
          check_field("command_code", 48'(want.command_code), 48'(m_axis_tdata[7:0]));
          check_field("chunk_lba", want.chunk_lba, m_axis_tdata[55:8]);
          check_field("chunk_sectors", 48'(want.chunk_sectors), 48'(m_axis_tdata[59:56]));
          check_field("prd_byte_count", 48'(want.prd_byte_count), 48'(m_axis_tdata[71:60]));
          check_field("is_write", 48'(want.is_write), 48'(m_axis_tdata[72]));
          check_field("status_code", 48'(want.status_code), 48'(m_axis_tdata[75:73]));
        end
      end
    end
  end

  // Nothing accepted on any channel for too long: the block is hung
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL sata_dma_transfer_sequencer_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/sdts_pkg.sv
hdl/sdts_out_q.sv
hdl/sdts_seq.sv
hdl/sata_dma_transfer_sequencer_unit.sv
dv/testbench.sv
